/* rtl/tfct_pkg.sv */
// Shared types and constants of the thermal fan and current throttle unit.
package tfct_pkg;

    typedef struct packed {
        logic signed [7:0] temperature;
        logic              lamp_on;
    } t_in;

    typedef struct packed {
        logic [9:0]  fan_duty;
        logic        fan_on;
        logic [15:0] current_limit_ma;
        logic        throttled;
    } t_out;

    typedef enum logic [2:0] {
        CFG_PWM_MODE      = 3'd0,
        CFG_TEMP_LOW      = 3'd1,
        CFG_TEMP_HIGH     = 3'd2,
        CFG_SPEED_FLOOR   = 3'd3,
        CFG_SPEED_CEILING = 3'd4,
        CFG_TEMP_TARGET   = 3'd5,
        CFG_FAIL_PERIOD   = 3'd6,
        CFG_START_LIMIT   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_RAMP,
        ST_DONE
    } t_state;

    typedef enum logic {
        DIV_SEL_MOD,
        DIV_SEL_RAMP
    } t_div_sel;

    typedef struct packed {
        logic     load_in;
        logic     div_start;
        t_div_sel div_sel;
        logic     mod_cap;
        logic     fix;
        logic     commit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

    typedef struct packed {
        logic        valid;
        t_cfg_idx    index;
        logic [15:0] data;
    } t_cfg_wr;

    // Divider geometry: 18-bit dividend, 9-bit divisor, one quotient bit per cycle.
    localparam int DIV_N_W   = 18;
    localparam int DIV_D_W   = 9;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd18;

    // x/10 for x < 1024 is (x*205) >> 11.
    localparam logic [7:0] DIV10_MUL   = 8'd205;
    // x/100 for 16-bit x is (x*83887) >> 23.
    localparam logic [16:0] RECIP100_MUL = 17'd83887;

    localparam logic              RST_PWM_MODE      = 1'b1;
    localparam logic signed [7:0] RST_TEMP_LOW      = 8'sd30;
    localparam logic signed [7:0] RST_TEMP_HIGH     = 8'sd60;
    localparam logic [9:0]        RST_SPEED_FLOOR   = 10'd0;
    localparam logic [9:0]        RST_SPEED_CEILING = 10'd1023;
    localparam logic [6:0]        RST_TEMP_TARGET   = 7'd50;
    localparam logic [7:0]        RST_FAIL_PERIOD   = 8'd10;
    localparam logic [15:0]       RST_START_LIMIT   = 16'd2000;

endpackage

/* rtl/tfct_div.sv */
// Restoring serial divider, one quotient bit per cycle.
module tfct_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [tfct_pkg::DIV_N_W-1:0]   i_dividend,
    input  logic [tfct_pkg::DIV_D_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic [tfct_pkg::DIV_N_W-1:0]   o_quot,
    output logic [tfct_pkg::DIV_D_W-1:0]   o_rem
);

    logic                             r_busy, n_busy;
    logic                             r_done, n_done;
    logic [tfct_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [tfct_pkg::DIV_N_W-1:0]     r_quo, n_quo;
    logic [tfct_pkg::DIV_D_W-1:0]     r_rem, n_rem;
    logic [tfct_pkg::DIV_D_W-1:0]     r_dvs, n_dvs;
    logic [tfct_pkg::DIV_D_W:0]       shifted;
    logic [tfct_pkg::DIV_D_W+1:0]     trial;

    always_comb begin
        shifted = {r_rem, r_quo[tfct_pkg::DIV_N_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_dvs};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = tfct_pkg::DIV_STEPS;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // The partial remainder stays below the divisor, so it fits DIV_D_W bits.
            if (!trial[tfct_pkg::DIV_D_W+1]) begin
                n_rem = trial[tfct_pkg::DIV_D_W-1:0];
                n_quo = {r_quo[tfct_pkg::DIV_N_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[tfct_pkg::DIV_D_W-1:0];
                n_quo = {r_quo[tfct_pkg::DIV_N_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - tfct_pkg::DIV_CNT_W'(1);
            if (r_cnt == tfct_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

/* rtl/tfct_ctrl.sv */
// Sequencing state machine of the thermal fan and current throttle unit.
module tfct_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  tfct_pkg::t_stat i_stat,
    output tfct_pkg::t_cmd  o_cmd
);

    tfct_pkg::t_state r_state, n_state;
    logic             r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tfct_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld && i_out_stall;
        o_cmd     = '0;
        unique case (r_state)
            tfct_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = tfct_pkg::DIV_SEL_MOD;
                    n_state         = tfct_pkg::ST_MOD;
                end
            end
            tfct_pkg::ST_MOD: begin
                if (i_stat.div_done) begin
                    o_cmd.mod_cap   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = tfct_pkg::DIV_SEL_RAMP;
                    n_state         = tfct_pkg::ST_RAMP;
                end
            end
            tfct_pkg::ST_RAMP: begin
                if (i_stat.div_done) begin
                    o_cmd.fix = 1'b1;
                    n_state   = tfct_pkg::ST_DONE;
                end
            end
            tfct_pkg::ST_DONE: begin
                // The result register frees up in the same cycle its request is taken.
                if (!r_out_vld || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_out_vld    = 1'b1;
                    n_state      = tfct_pkg::ST_IDLE;
                end
            end
            default: n_state = tfct_pkg::ST_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != tfct_pkg::ST_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

/* rtl/tfct_dpath.sv */
// Datapath: configuration, fan ramp, hysteresis, tick counter and current limit.
module tfct_dpath #(
    parameter int LIMIT_STEP_PERCENT = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tfct_pkg::t_cfg_wr i_cfg,
    input  tfct_pkg::t_in     i_in_data,
    input  tfct_pkg::t_cmd    i_cmd,
    output tfct_pkg::t_stat   o_stat,
    output tfct_pkg::t_out    o_out_data
);

    localparam logic [6:0] STEP = LIMIT_STEP_PERCENT[6:0];
    localparam logic       STEP_ON = (LIMIT_STEP_PERCENT > 0);

    // Configuration
    logic              r_pwm;
    logic signed [7:0] r_tlo, r_thi;
    logic [9:0]        r_sflo, r_sceil;
    logic [6:0]        r_tgt;
    logic [7:0]        r_fper;

    // Block state
    logic        r_fan, n_fan;
    logic [7:0]  r_tick, n_tick;
    logic [15:0] r_limit, n_limit;

    // Sample and intermediate results
    logic signed [7:0] r_t;
    logic              r_lamp;
    logic [17:0]       r_num;
    logic [8:0]        r_den;
    logic              r_neg;
    logic [7:0]        r_hi;
    logic [6:0]        r_lo;
    logic [9:0]        r_q100;
    logic [15:0]       r_cut;
    logic              r_modz;
    logic [9:0]        r_duty;
    tfct_pkg::t_out    r_out, n_out;

    logic signed [8:0]  dt;
    logic signed [10:0] spd;
    logic [9:0]         spd_mag;
    logic signed [8:0]  den;
    logic [14:0]        tgt_x;
    logic [3:0]         tgt_d10;
    logic [32:0]        lim_x;
    logic [16:0]        cut_x;

    logic [17:0] div_dvd;
    logic [8:0]  div_dvs;
    logic        div_done;
    logic [17:0] div_quo;
    logic [8:0]  div_rem;

    logic signed [19:0] ramp_val;
    logic [9:0]         n_duty;
    logic signed [8:0]  t_ext, hot;
    logic [7:0]         tick_inc;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm   <= tfct_pkg::RST_PWM_MODE;
            r_tlo   <= tfct_pkg::RST_TEMP_LOW;
            r_thi   <= tfct_pkg::RST_TEMP_HIGH;
            r_sflo  <= tfct_pkg::RST_SPEED_FLOOR;
            r_sceil <= tfct_pkg::RST_SPEED_CEILING;
            r_tgt   <= tfct_pkg::RST_TEMP_TARGET;
            r_fper  <= tfct_pkg::RST_FAIL_PERIOD;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tfct_pkg::CFG_PWM_MODE:      r_pwm   <= i_cfg.data[0];
                tfct_pkg::CFG_TEMP_LOW:      r_tlo   <= $signed(i_cfg.data[7:0]);
                tfct_pkg::CFG_TEMP_HIGH:     r_thi   <= $signed(i_cfg.data[7:0]);
                tfct_pkg::CFG_SPEED_FLOOR:   r_sflo  <= i_cfg.data[9:0];
                tfct_pkg::CFG_SPEED_CEILING: r_sceil <= i_cfg.data[9:0];
                tfct_pkg::CFG_TEMP_TARGET:   r_tgt   <= i_cfg.data[6:0];
                tfct_pkg::CFG_FAIL_PERIOD:   r_fper  <= i_cfg.data[7:0];
                tfct_pkg::CFG_START_LIMIT:   ;
                default: ;
            endcase
        end
    end

    // Operands that follow the stored sample and configuration, refreshed every cycle.
    always_comb begin
        dt      = {r_t[7], r_t} - {r_tlo[7], r_tlo};
        spd     = $signed({1'b0, r_sceil}) - $signed({1'b0, r_sflo});
        spd_mag = spd[10] ? 10'(-spd) : spd[9:0];
        den     = {r_thi[7], r_thi} - {r_tlo[7], r_tlo};
        tgt_x   = 15'(r_tgt) * 15'(tfct_pkg::DIV10_MUL);
        tgt_d10 = tgt_x[14:11];
        lim_x   = 33'(r_limit) * 33'(tfct_pkg::RECIP100_MUL);
        cut_x   = 17'(r_q100) * 17'(STEP);
    end

    always_ff @(posedge i_clk) begin
        // The difference is only used when it is not negative, so eight bits hold it.
        r_num  <= 18'(dt[7:0]) * 18'(spd_mag);
        r_den  <= den[8] ? 9'(-den) : den;
        r_neg  <= spd[10] ^ den[8];
        r_hi   <= {1'b0, r_tgt} + {4'b0, tgt_d10};
        r_lo   <= r_tgt - {3'b0, tgt_d10};
        r_q100 <= lim_x[32:23];
        r_cut  <= cut_x[15:0];
    end

    // Shared divider: first the tick counter modulo the period, then the ramp.
    assign tick_inc = r_tick + 8'd1;

    always_comb begin
        if (i_cmd.div_sel == tfct_pkg::DIV_SEL_MOD) begin
            div_dvd = {10'b0, tick_inc};
            div_dvs = (r_fper == 8'd0) ? 9'd256 : {1'b0, r_fper};
        end else begin
            div_dvd = r_num;
            div_dvs = r_den;
        end
    end

    tfct_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quo),
        .o_rem      (div_rem)
    );

    assign o_stat.div_done = div_done;

    // Ramp result with truncation toward zero, then the clamp.
    always_comb begin
        ramp_val = (r_neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo}))
                 + $signed({10'b0, r_sflo});
        if (r_t < r_tlo) begin
            n_duty = '0;
        end else if (r_thi == r_tlo) begin
            n_duty = r_sceil;
        end else if (ramp_val < 0) begin
            n_duty = '0;
        end else if (ramp_val > $signed({10'b0, r_sceil})) begin
            n_duty = r_sceil;
        end else begin
            n_duty = ramp_val[9:0];
        end
    end

    // Result and state update for the finished sample.
    always_comb begin
        t_ext   = {r_t[7], r_t};
        n_fan   = r_fan;
        n_tick  = r_tick;
        n_limit = r_limit;
        n_out   = '0;
        if (r_pwm) begin
            n_out.fan_duty = r_duty;
            hot            = {r_thi[7], r_thi};
        end else begin
            if (t_ext >= $signed({1'b0, r_hi}) && !r_fan) begin
                n_fan = 1'b1;
            end else if (t_ext <= $signed({2'b00, r_lo}) && r_fan) begin
                n_fan = 1'b0;
            end
            n_out.fan_on = n_fan;
            hot          = $signed({1'b0, r_hi});
        end
        if (r_lamp && STEP_ON) begin
            n_tick = tick_inc;
            if (r_modz && (t_ext > hot)) begin
                n_limit         = r_limit - r_cut;
                n_tick          = '0;
                n_out.throttled = 1'b1;
            end
        end
        n_out.current_limit_ma = n_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fan   <= 1'b0;
            r_tick  <= '0;
            r_limit <= tfct_pkg::RST_START_LIMIT;
        end else if (i_cfg.valid && i_cfg.index == tfct_pkg::CFG_START_LIMIT) begin
            r_limit <= i_cfg.data;
        end else if (i_cmd.commit) begin
            r_fan   <= n_fan;
            r_tick  <= n_tick;
            r_limit <= n_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_t    <= i_in_data.temperature;
            r_lamp <= i_in_data.lamp_on;
        end
        if (i_cmd.mod_cap) begin
            r_modz <= (div_rem == '0);
        end
        if (i_cmd.fix) begin
            r_duty <= n_duty;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

/* rtl/thermal_fan_and_current_throttle_unit.sv */
// Thermal fan and current throttle unit: top level.
//
// Input channel: one request carries a signed temperature in whole degrees and a
// lamp-on flag; it is taken at a clock edge with i_in_valid high and o_in_stall low.
// Output channel: one result request per input (fan duty, fan switch, current limit,
// throttle flag), taken at an edge with o_out_valid high and i_out_stall low.
// Configuration: eight registers written through i_cfg_valid/o_cfg_ready with a
// 3-bit index; o_cfg_ready is always high. Writing the start limit also reloads
// the running current limit. The user must make writes only while no sample is
// in flight; the block itself does not enforce this. One sample is worked on at
// a time; the next sample is taken once the result of the last one is committed.
// The shared serial divider runs 18 steps for the tick counter modulo the fail
// period and then 18 steps for the fan ramp quotient.
// Reset (synchronous, active low) loads the default configuration, turns the fan
// flag off, clears the tick counter and loads the default current limit.
// A stalled result holds in the output register; the next sample is still taken
// and processed, and only its final step waits until the held result is taken.
module thermal_fan_and_current_throttle_unit #(
    parameter int LIMIT_STEP_PERCENT = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  tfct_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output tfct_pkg::t_out  o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data
);

    tfct_pkg::t_cmd    cmd;
    tfct_pkg::t_stat   stat;
    tfct_pkg::t_cfg_wr cfg_wr;

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = tfct_pkg::t_cfg_idx'(i_cfg_index);
    assign cfg_wr.data  = i_cfg_data;

    tfct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tfct_dpath #(
        .LIMIT_STEP_PERCENT (LIMIT_STEP_PERCENT)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg_wr),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule

/* rtl/tfct_checker.sv */
// Port-level checks of the thermal fan and current throttle unit, bound to the top level.
module tfct_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall
);

    // A held result stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result request dropped while stalled");

    // Only one sample is worked on at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a sample was taken");

    // A new result only ever closes a busy period.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(o_out_valid)) |-> $past(o_in_stall))
        else $error("result appeared without a sample in flight");

    // The block frees its input only by issuing the result of the sample it held.
    a_free_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(o_in_stall)) |-> o_out_valid)
        else $error("input freed without a result");

endmodule

bind thermal_fan_and_current_throttle_unit tfct_checker u_tfct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);

/* tb/tb_top.sv */
// Self-checking testbench for the thermal fan and current throttle unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int STEP_PERCENT   = 5;
    localparam int DRAIN_CYCLES   = 48;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NUM_PHASES     = 8;

    typedef struct {
        bit                 is_cfg;
        tfct_pkg::t_cfg_idx idx;
        logic [15:0]        data;
        int                 temp;
        bit                 lamp;
        bit                 fixed;
        tfct_pkg::t_out     want;
    } t_row;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    tfct_pkg::t_in  i_in_data;
    logic           o_out_valid;
    logic           i_out_stall;
    tfct_pkg::t_out o_out_data;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [2:0]     i_cfg_index;
    logic [15:0]    i_cfg_data;

    // Our own copy of the block's configuration and state.
    logic              p_pwm_mode      = tfct_pkg::RST_PWM_MODE;
    logic signed [7:0] p_temp_low      = tfct_pkg::RST_TEMP_LOW;
    logic signed [7:0] p_temp_high     = tfct_pkg::RST_TEMP_HIGH;
    logic [9:0]        p_speed_floor   = tfct_pkg::RST_SPEED_FLOOR;
    logic [9:0]        p_speed_ceiling = tfct_pkg::RST_SPEED_CEILING;
    logic [6:0]        p_target        = tfct_pkg::RST_TEMP_TARGET;
    logic [7:0]        p_fail_period   = tfct_pkg::RST_FAIL_PERIOD;
    logic              p_fan_state     = 1'b0;
    logic [7:0]        p_ticks         = 8'd0;
    logic [15:0]       p_limit         = tfct_pkg::RST_START_LIMIT;

    tfct_pkg::t_out pending_fan_limit[$];
    t_row           directed_rows[$];
    int             fail_count = 0;
    int             snd_max    = 7;
    int             rcv_max    = 7;
    bit             hold_req   = 1'b0;
    bit             row_fixed  = 1'b0;
    tfct_pkg::t_out row_want   = '0;

    thermal_fan_and_current_throttle_unit #(
        .LIMIT_STEP_PERCENT(STEP_PERCENT)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic compute_fan_and_limit(input tfct_pkg::t_in s, output tfct_pkg::t_out r);
        int t, hi_thr, lo_thr, hot, num, den, val, period;
        r = '0;
        t = int'(s.temperature);
        hi_thr = int'(p_target) + int'(p_target) / 10;
        lo_thr = int'(p_target) - int'(p_target) / 10;
        if (p_pwm_mode) begin
            if (t < int'(p_temp_low)) begin
                val = 0;
            end else if (p_temp_high == p_temp_low) begin
                val = int'(p_speed_ceiling);
            end else begin
                num = (t - int'(p_temp_low)) * (int'(p_speed_ceiling) - int'(p_speed_floor));
                den = int'(p_temp_high) - int'(p_temp_low);
                val = num / den + int'(p_speed_floor);
                if (val < 0) val = 0;
                if (val > int'(p_speed_ceiling)) val = int'(p_speed_ceiling);
            end
            r.fan_duty = 10'(val);
            hot = int'(p_temp_high);
        end else begin
            if (t >= hi_thr && !p_fan_state) begin
                p_fan_state = 1'b1;
            end else if (t <= lo_thr && p_fan_state) begin
                p_fan_state = 1'b0;
            end
            r.fan_on = p_fan_state;
            hot = hi_thr;
        end
        if (s.lamp_on && STEP_PERCENT > 0) begin
            p_ticks = p_ticks + 8'd1;
            // A zero period behaves as 256, so only the wrapped counter matches.
            period = (p_fail_period == 8'd0) ? 256 : int'(p_fail_period);
            if ((int'(p_ticks) % period) == 0 && t > hot) begin
                p_limit = p_limit - 16'((p_limit / 16'd100) * STEP_PERCENT);
                p_ticks = 8'd0;
                r.throttled = 1'b1;
            end
        end
        r.current_limit_ma = p_limit;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        tfct_pkg::t_out want;
        tfct_pkg::t_out got;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_fan_limit.size() == 0) begin
                    $display("%0t: result request with none expected, expected none, actual %h",
                             $time, o_out_data);
                    fail_count++;
                end else begin
                    want = pending_fan_limit.pop_front();
                    check_field("fan_duty", want.fan_duty, o_out_data.fan_duty);
                    check_field("fan_on", want.fan_on, o_out_data.fan_on);
                    check_field("current_limit_ma", want.current_limit_ma,
                                o_out_data.current_limit_ma);
                    check_field("throttled", want.throttled, o_out_data.throttled);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                compute_fan_and_limit(i_in_data, got);
                pending_fan_limit.push_back(row_fixed ? row_want : got);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tfct_pkg::CFG_PWM_MODE:      p_pwm_mode      = i_cfg_data[0];
                    tfct_pkg::CFG_TEMP_LOW:      p_temp_low      = i_cfg_data[7:0];
                    tfct_pkg::CFG_TEMP_HIGH:     p_temp_high     = i_cfg_data[7:0];
                    tfct_pkg::CFG_SPEED_FLOOR:   p_speed_floor   = i_cfg_data[9:0];
                    tfct_pkg::CFG_SPEED_CEILING: p_speed_ceiling = i_cfg_data[9:0];
                    tfct_pkg::CFG_TEMP_TARGET:   p_target        = i_cfg_data[6:0];
                    tfct_pkg::CFG_FAIL_PERIOD:   p_fail_period   = i_cfg_data[7:0];
                    tfct_pkg::CFG_START_LIMIT:   p_limit         = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : result_sink
        int n;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                // Long hold-off so the block fills up and stalls its input.
                hold_req = 1'b0;
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                n = (rcv_max == 0) ? 0 : $urandom_range(0, rcv_max);
                if (n > 0) begin
                    i_out_stall = 1'b1;
                    repeat (n) @(negedge i_clk);
                end
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    task automatic send_sample(input int temp, input bit lamp, input bit fixed,
                               input tfct_pkg::t_out want);
        int gap;
        gap = (snd_max == 0) ? 0 : $urandom_range(0, snd_max);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data.temperature = 8'(temp);
        i_in_data.lamp_on     = lamp;
        row_fixed             = fixed;
        row_want              = want;
        i_in_valid            = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic cfg_write(input tfct_pkg::t_cfg_idx idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic settle_block();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_fan_limit.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic void cfg_row(input tfct_pkg::t_cfg_idx idx, input logic [15:0] data);
        t_row r;
        r = '{is_cfg: 1'b1, idx: idx, data: data, temp: 0, lamp: 1'b0, fixed: 1'b0, want: '0};
        directed_rows.push_back(r);
    endfunction

    function automatic void smp_row(input int temp, input bit lamp);
        t_row r;
        r = '{is_cfg: 1'b0, idx: tfct_pkg::CFG_PWM_MODE, data: '0, temp: temp, lamp: lamp,
              fixed: 1'b0, want: '0};
        directed_rows.push_back(r);
    endfunction

    function automatic void known_row(input int temp, input bit lamp, input int duty,
                                      input bit fan, input int lim, input bit cut);
        t_row r;
        r = '{is_cfg: 1'b0, idx: tfct_pkg::CFG_PWM_MODE, data: '0, temp: temp, lamp: lamp,
              fixed: 1'b1, want: '0};
        r.want.fan_duty         = 10'(duty);
        r.want.fan_on           = fan;
        r.want.current_limit_ma = 16'(lim);
        r.want.throttled        = cut;
        directed_rows.push_back(r);
    endfunction

    // Mostly samples near the ramp ends and switching points, some anywhere.
    function automatic int pick_temp();
        int base, t;
        if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 180)) - 55;
        case ($urandom_range(0, 3))
            0:       base = int'(p_temp_low);
            1:       base = int'(p_temp_high);
            2:       base = int'(p_target) + int'(p_target) / 10;
            default: base = int'(p_target) - int'(p_target) / 10;
        endcase
        t = base + int'($urandom_range(0, 10)) - 5;
        if (t < -55) t = -55;
        if (t > 125) t = 125;
        return t;
    endfunction

    task automatic program_phase(input int p);
        logic [15:0] junk;
        int          tl, th;
        junk = 16'($urandom);
        if (p == 0) begin
            cfg_write(tfct_pkg::CFG_PWM_MODE, 16'd0);
            cfg_write(tfct_pkg::CFG_TEMP_LOW, 16'(-55));
            cfg_write(tfct_pkg::CFG_TEMP_HIGH, 16'(-55));
            cfg_write(tfct_pkg::CFG_SPEED_FLOOR, 16'd0);
            cfg_write(tfct_pkg::CFG_SPEED_CEILING, 16'd0);
            cfg_write(tfct_pkg::CFG_TEMP_TARGET, 16'd0);
            cfg_write(tfct_pkg::CFG_FAIL_PERIOD, 16'd1);
            cfg_write(tfct_pkg::CFG_START_LIMIT, 16'd0);
        end else if (p == 1) begin
            cfg_write(tfct_pkg::CFG_PWM_MODE, 16'd1);
            cfg_write(tfct_pkg::CFG_TEMP_LOW, 16'd125);
            cfg_write(tfct_pkg::CFG_TEMP_HIGH, 16'd125);
            cfg_write(tfct_pkg::CFG_SPEED_FLOOR, 16'd1023);
            cfg_write(tfct_pkg::CFG_SPEED_CEILING, 16'd1023);
            cfg_write(tfct_pkg::CFG_TEMP_TARGET, 16'd125);
            cfg_write(tfct_pkg::CFG_FAIL_PERIOD, 16'd255);
            cfg_write(tfct_pkg::CFG_START_LIMIT, 16'hFFFF);
        end else begin
            tl = int'($urandom_range(0, 180)) - 55;
            th = ($urandom_range(0, 7) == 0) ? tl : int'($urandom_range(0, 180)) - 55;
            cfg_write(tfct_pkg::CFG_PWM_MODE, {junk[15:1], 1'($urandom_range(0, 1))});
            cfg_write(tfct_pkg::CFG_TEMP_LOW, {junk[15:8], 8'(tl)});
            cfg_write(tfct_pkg::CFG_TEMP_HIGH, {junk[15:8], 8'(th)});
            cfg_write(tfct_pkg::CFG_SPEED_FLOOR, {junk[15:10], 10'($urandom_range(0, 1023))});
            cfg_write(tfct_pkg::CFG_SPEED_CEILING,
                      {junk[15:10], ($urandom_range(0, 3) == 0) ? 10'd1023
                                                                : 10'($urandom_range(0, 1023))});
            cfg_write(tfct_pkg::CFG_TEMP_TARGET, {junk[15:7], 7'($urandom_range(0, 125))});
            if (p == 2) begin
                cfg_write(tfct_pkg::CFG_FAIL_PERIOD, {junk[15:8], 8'd0});
            end else begin
                cfg_write(tfct_pkg::CFG_FAIL_PERIOD, {junk[15:8], 8'($urandom_range(1, 12))});
            end
            if ($urandom_range(0, 1) == 0) begin
                cfg_write(tfct_pkg::CFG_START_LIMIT, 16'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        int   p, k, count;
        bit   after_sample;
        t_row r;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = tfct_pkg::CFG_PWM_MODE;
        i_cfg_data  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Defaults after reset: ramp 30..60 onto 0..1023, limit 2000.
        known_row(-55, 1'b0, 0, 1'b0, 2000, 1'b0);
        known_row(29, 1'b0, 0, 1'b0, 2000, 1'b0);
        known_row(30, 1'b0, 0, 1'b0, 2000, 1'b0);
        known_row(60, 1'b0, 1023, 1'b0, 2000, 1'b0);
        known_row(125, 1'b1, 1023, 1'b0, 2000, 1'b0);
        smp_row(45, 1'b1);
        cfg_row(tfct_pkg::CFG_FAIL_PERIOD, 16'd1);
        known_row(61, 1'b1, 1023, 1'b0, 1900, 1'b1);
        smp_row(60, 1'b1);
        cfg_row(tfct_pkg::CFG_START_LIMIT, 16'hFFFF);
        known_row(125, 1'b1, 1023, 1'b0, 62260, 1'b1);
        cfg_row(tfct_pkg::CFG_START_LIMIT, 16'd0);
        known_row(125, 1'b1, 1023, 1'b0, 0, 1'b1);
        // Equal ramp ends saturate at the ceiling.
        cfg_row(tfct_pkg::CFG_TEMP_HIGH, 16'd30);
        known_row(30, 1'b0, 1023, 1'b0, 0, 1'b0);
        known_row(29, 1'b0, 0, 1'b0, 0, 1'b0);
        // Reversed ramp gives a negative divisor.
        cfg_row(tfct_pkg::CFG_TEMP_LOW, 16'd10);
        cfg_row(tfct_pkg::CFG_TEMP_HIGH, 16'(-55));
        cfg_row(tfct_pkg::CFG_SPEED_FLOOR, 16'd500);
        smp_row(50, 1'b0);
        smp_row(125, 1'b0);
        cfg_row(tfct_pkg::CFG_SPEED_CEILING, 16'd0);
        cfg_row(tfct_pkg::CFG_TEMP_LOW, 16'(-55));
        cfg_row(tfct_pkg::CFG_TEMP_HIGH, 16'd125);
        smp_row(125, 1'b0);
        smp_row(0, 1'b1);
        // On/off mode with hysteresis at 55 and 45.
        cfg_row(tfct_pkg::CFG_PWM_MODE, 16'd0);
        cfg_row(tfct_pkg::CFG_TEMP_TARGET, 16'd50);
        cfg_row(tfct_pkg::CFG_START_LIMIT, 16'd2000);
        cfg_row(tfct_pkg::CFG_FAIL_PERIOD, 16'd0);
        known_row(54, 1'b0, 0, 1'b0, 2000, 1'b0);
        known_row(55, 1'b0, 0, 1'b1, 2000, 1'b0);
        known_row(46, 1'b0, 0, 1'b1, 2000, 1'b0);
        known_row(45, 1'b0, 0, 1'b0, 2000, 1'b0);
        // With a zero target both switching points sit at zero.
        cfg_row(tfct_pkg::CFG_TEMP_TARGET, 16'd0);
        known_row(0, 1'b0, 0, 1'b1, 2000, 1'b0);
        known_row(-55, 1'b0, 0, 1'b0, 2000, 1'b0);
        cfg_row(tfct_pkg::CFG_TEMP_TARGET, 16'd125);
        smp_row(125, 1'b1);

        after_sample = 1'b0;
        foreach (directed_rows[k]) begin
            r = directed_rows[k];
            if (r.is_cfg) begin
                if (after_sample) settle_block();
                after_sample = 1'b0;
                cfg_write(r.idx, r.data);
            end else begin
                send_sample(r.temp, r.lamp, r.fixed, r.want);
                after_sample = 1'b1;
            end
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            settle_block();
            program_phase(p);
            snd_max = (p % 3 == 0) ? 0 : 7;
            rcv_max = (p % 4 == 1) ? 0 : 7;
            if (p == 3) hold_req = 1'b1;
            // The zero-period phase runs long enough for the tick counter to wrap.
            count = (p == 2) ? 300 : 220;
            for (k = 0; k < count; k++) begin
                send_sample(pick_temp(), (p == 2) ? ($urandom_range(0, 7) != 0)
                                                  : ($urandom_range(0, 3) != 0),
                            1'b0, '0);
            end
        end

        settle_block();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/tfct_pkg.sv
rtl/tfct_div.sv
rtl/tfct_ctrl.sv
rtl/tfct_dpath.sv
rtl/thermal_fan_and_current_throttle_unit.sv
rtl/tfct_checker.sv
tb/tb_top.sv
